// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the k-mer allele counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define KMAC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define KMAC_ASSERT(lbl, prop, msg) \
    `KMAC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/kmac_pkg.sv
// Package of the k-mer allele counter: types, codes, constants and helpers.
`default_nettype none
package kmac_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 65536;
    localparam int unsigned SITE_COUNT_DEF    = 16384;
    localparam int unsigned COUNT_BITS_DEF    = 32;

    localparam logic [63:0] HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [5:0]  KLEN_RST  = 6'd21;
    localparam logic [5:0]  KLEN_MAX  = 6'd32;
    localparam logic [5:0]  KLEN_MIN  = 6'd1;

    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_C = 8'h43;
    localparam logic [7:0] ASCII_G = 8'h47;
    localparam logic [7:0] ASCII_T = 8'h54;

    localparam logic [0:0] CFG_KMER_LEN = 1'b0;
    localparam logic [0:0] CFG_PAIRED   = 1'b1;

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_DECOY = 3'd1,
        CMD_BASE  = 3'd2,
        CMD_QUERY = 3'd3,
        CMD_CLEAR = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_MUL,
        S_SUM,
        S_MOD,
        S_PROBE,
        S_CHECK,
        S_CREAD,
        S_CWRITE,
        S_QREAD,
        S_FINBASE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic        decoy;
        logic        alt;
        logic [13:0] site;
        logic [63:0] key;
    } t_tbl_ent;

    // Effective k: zero acts as one, anything above 32 acts as 32.
    function automatic logic [5:0] eff_k(input logic [5:0] k);
        logic [5:0] r;
        r = k;
        if (k == 6'd0) r = KLEN_MIN;
        else if (k > KLEN_MAX) r = KLEN_MAX;
        return r;
    endfunction

    function automatic logic [63:0] key_mask(input logic [5:0] k);
        logic [63:0] m;
        if (k >= KLEN_MAX) m = '1;
        else m = (64'd1 << {k, 1'b0}) - 64'd1;
        return m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/kmac_in_if.sv
// Request channel of the k-mer allele counter.
`default_nettype none
interface kmac_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [63:0] pattern_key;
    logic [13:0] site_index;
    logic        alt_allele;
    logic [7:0]  base_char;
    logic        end_of_read;
    logic        second_mate;

    modport source (output valid, command, pattern_key, site_index, alt_allele,
                    base_char, end_of_read, second_mate, input ready);
    modport sink   (input valid, command, pattern_key, site_index, alt_allele,
                    base_char, end_of_read, second_mate, output ready);
endinterface
`default_nettype wire

// File: rtl/kmac_out_if.sv
// Result channel of the k-mer allele counter.
`default_nettype none
interface kmac_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] ref_count;
    logic [31:0] alt_count;
    logic [31:0] decoy_count;

    modport source (output valid, status, ref_count, alt_count, decoy_count,
                    input ready);
    modport sink   (input valid, status, ref_count, alt_count, decoy_count,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/kmer_match_allele_counter_core.sv
// Top level of the k-mer allele counter: pattern table, site counters, read scan.
`default_nettype none
`include "assert_macros.svh"
// The block keeps a linear-probing hash table of k-mer patterns in one
// synchronous memory and the per-site ref/alt counters in a second one. After
// reset it sweeps both memories, one entry a cycle, while the request channel
// is held not ready; configuration writes are taken at any time. A
// clear-counts request sweeps the counter memory again before its result. A
// read base that does not probe, because it completes no clean window or its
// read already hit, is taken without leaving the idle state. A base that
// completes a window is hashed (a multiply stage, a fold stage and the slot
// reduction, which repeats its modulo state when TABLE_ENTRIES is not a power
// of two) and then probes the table, a read state and a check state per slot,
// stepping to the next slot on each collision; a site hit adds a
// read-modify-write of the counter memory. Pattern loads take the same hash
// and probe path. A query reads the counter memory before its result. A
// finished result sits in an output register, so the next request is taken
// while it waits to be drained.
module kmer_match_allele_counter_core
    import kmac_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int unsigned SITE_COUNT    = SITE_COUNT_DEF,
    parameter int unsigned COUNT_BITS    = COUNT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [0:0]  i_cfg_idx,
    input  wire [5:0]  i_cfg_data,
    kmac_in_if.sink    i_req,
    kmac_out_if.source o_res
);

    localparam int unsigned TW   = $clog2(TABLE_ENTRIES);
    localparam int unsigned SAW  = (SITE_COUNT > 2) ? $clog2(SITE_COUNT) : 1;
    localparam int unsigned UW   = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned SWMAX = (TABLE_ENTRIES > SITE_COUNT) ? TABLE_ENTRIES : SITE_COUNT;
    localparam int unsigned SWW  = $clog2(SWMAX + 1);
    localparam bit          TBL_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [TW:0]    TBL_N   = (TW + 1)'(TABLE_ENTRIES);
    localparam logic [TW-1:0]  TBL_TOP = TW'(TABLE_ENTRIES - 1);
    localparam logic [UW-1:0]  USED_N  = UW'(TABLE_ENTRIES);
    localparam logic [16:0]    SITE_N  = 17'(SITE_COUNT);
    localparam logic [SWW-1:0] SW_TBL_END = SWW'(SWMAX - 1);
    localparam logic [SWW-1:0] SW_CNT_END = SWW'(SITE_COUNT - 1);
    localparam logic [SWW-1:0] SW_TBL_N   = SWW'(TABLE_ENTRIES);
    localparam logic [SWW-1:0] SW_CNT_N   = SWW'(SITE_COUNT);

    // Memories.
    t_tbl_ent                  tbl_mem [TABLE_ENTRIES];
    logic [2*COUNT_BITS-1:0]   cnt_mem [SITE_COUNT];

    t_state                    r_state, n_state;
    t_tbl_ent                  r_tbl_q;
    logic [2*COUNT_BITS-1:0]   r_cnt_q;

    // Configuration.
    logic [5:0]                r_kmer_len;
    logic                      r_paired;

    // Read scan state.
    logic [63:0]               r_window;
    logic [5:0]                r_clean;
    logic                      r_hit;
    logic                      r_open;
    logic                      r_eor;
    logic                      r_mate2;

    // Request context.
    logic                      r_is_base;
    logic                      r_is_query;
    logic [63:0]               r_key;
    logic                      r_tag_decoy;
    logic                      r_tag_alt;
    logic [13:0]               r_site;
    logic                      r_cnt_alt;
    t_status                   r_status;

    // Hash and probe.
    logic [63:0]               r_pll;
    logic [31:0]               r_plh;
    logic [31:0]               r_phl;
    logic [63:0]               r_hash;
    logic [TW:0]               r_rem;
    logic [2:0]                r_mstep;
    logic [TW-1:0]             r_slot;
    logic [TW:0]               r_pcnt;
    logic [UW-1:0]             r_used;
    logic [COUNT_BITS-1:0]     r_decoy;

    // Sweep.
    logic [SWW-1:0]            r_sweep;
    logic                      r_sweep_tbl;

    // Output register.
    logic                      r_ov;
    logic [1:0]                r_o_status;
    logic [31:0]               r_o_ref;
    logic [31:0]               r_o_alt;
    logic [31:0]               r_o_decoy;

    // Combinational control.
    logic                      req_acc;
    logic                      res_free;
    logic                      tbl_we;
    logic [TW-1:0]             tbl_waddr;
    t_tbl_ent                  tbl_wdata;
    logic                      cnt_we;
    logic [SAW-1:0]            cnt_addr;
    logic [2*COUNT_BITS-1:0]   cnt_wdata;

    // Decode of the base being accepted.
    logic [5:0]                k_eff;
    logic [1:0]                base_code;
    logic                      base_ok;
    logic [63:0]               win_next;
    logic [5:0]                clean_next;
    logic                      hit_start;
    logic                      do_probe;

    // Probe decode.
    logic                      ent_match;
    logic                      ent_free;
    logic                      probe_last;
    logic [COUNT_BITS-1:0]     cnt_ref_q;
    logic [COUNT_BITS-1:0]     cnt_alt_q;

    // Hash fold and slot reduction.
    logic [63:0]               h_sum;
    logic [TW:0]               rem_steps;

    assign req_acc    = i_req.valid && i_req.ready;
    assign res_free   = !r_ov || o_res.ready;
    assign k_eff      = eff_k(r_kmer_len);
    assign ent_match  = r_tbl_q.valid && (r_tbl_q.key == r_key);
    assign ent_free   = !r_tbl_q.valid;
    assign probe_last = (r_pcnt == TBL_N - 1'b1);
    assign cnt_ref_q  = r_cnt_q[COUNT_BITS-1:0];
    assign cnt_alt_q  = r_cnt_q[2*COUNT_BITS-1:COUNT_BITS];
    assign cnt_addr   = (r_state == S_SWEEP) ? r_sweep[SAW-1:0] : SAW'(r_site);

    always_comb begin
        base_code = 2'd0;
        base_ok   = 1'b1;
        unique case (i_req.base_char)
            ASCII_A: base_code = 2'd0;
            ASCII_C: base_code = 2'd1;
            ASCII_G: base_code = 2'd2;
            ASCII_T: base_code = 2'd3;
            default: base_ok   = 1'b0;
        endcase
        win_next   = base_ok ? {r_window[61:0], base_code} : r_window;
        clean_next = !base_ok ? 6'd0 : (r_clean < KLEN_MAX) ? r_clean + 6'd1 : r_clean;
        // A new read clears the hit flag unless it is a second mate.
        hit_start  = (!r_open && !i_req.second_mate) ? 1'b0 : r_hit;
        do_probe   = base_ok && (clean_next >= k_eff) && !hit_start;
    end

    // Fold of the 64-bit product, then eight remainder steps of the slot reduction.
    always_comb begin
        h_sum     = r_pll + {r_plh + r_phl, 32'd0};
        rem_steps = r_rem;
        for (int i = 0; i < 8; i++) begin
            rem_steps = {rem_steps[TW-1:0], r_hash[63-i]};
            if (rem_steps >= TBL_N) rem_steps = rem_steps - TBL_N;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_SWEEP: begin
                if (r_sweep_tbl ? (r_sweep == SW_TBL_END) : (r_sweep == SW_CNT_END))
                    n_state = r_sweep_tbl ? S_IDLE : S_EMIT;
            end
            S_IDLE: begin
                if (req_acc) begin
                    unique case (i_req.command)
                        CMD_LOAD:  n_state = ({3'd0, i_req.site_index} >= SITE_N) ? S_EMIT : S_MUL;
                        CMD_DECOY: n_state = S_MUL;
                        CMD_BASE:  n_state = do_probe ? S_MUL : S_IDLE;
                        CMD_QUERY: n_state = ({3'd0, i_req.site_index} >= SITE_N) ? S_EMIT : S_QREAD;
                        CMD_CLEAR: n_state = S_SWEEP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_MOD;
            S_MOD:   if (TBL_POW2 || r_mstep == 3'd7) n_state = S_PROBE;
            S_PROBE: n_state = S_CHECK;
            S_CHECK: begin
                if (ent_free || ent_match) begin
                    if (!r_is_base) n_state = S_EMIT;
                    else if (ent_free || r_tbl_q.decoy) n_state = S_FINBASE;
                    else if ({3'd0, r_tbl_q.site} < SITE_N) n_state = S_CREAD;
                    else n_state = S_FINBASE;
                end else if (probe_last) begin
                    n_state = r_is_base ? S_FINBASE : S_EMIT;
                end else begin
                    n_state = S_PROBE;
                end
            end
            S_CREAD:   n_state = S_CWRITE;
            S_CWRITE:  n_state = S_FINBASE;
            S_QREAD:   n_state = S_EMIT;
            S_FINBASE: n_state = S_IDLE;
            S_EMIT:    if (res_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control outputs and memory write ports.
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        tbl_we      = 1'b0;
        tbl_waddr   = r_slot;
        tbl_wdata   = '{valid: 1'b1, decoy: r_tag_decoy, alt: r_tag_alt,
                        site: r_site, key: r_key};
        cnt_we      = 1'b0;
        cnt_wdata   = '0;
        unique case (r_state)
            S_SWEEP: begin
                tbl_we    = r_sweep_tbl && (r_sweep < SW_TBL_N);
                tbl_waddr = r_sweep[TW-1:0];
                tbl_wdata = '0;
                cnt_we    = (r_sweep < SW_CNT_N);
            end
            S_CHECK: begin
                if (!r_is_base) begin
                    if (ent_match) tbl_we = 1'b1;
                    else if (ent_free) tbl_we = (r_used < USED_N);
                end
            end
            S_CWRITE: begin
                cnt_we    = 1'b1;
                cnt_wdata = r_cnt_q;
                if (r_cnt_alt) begin
                    if (!(&cnt_alt_q))
                        cnt_wdata[2*COUNT_BITS-1:COUNT_BITS] = cnt_alt_q + 1'b1;
                end else begin
                    if (!(&cnt_ref_q))
                        cnt_wdata[COUNT_BITS-1:0] = cnt_ref_q + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tbl_q <= tbl_mem[r_slot];
        if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    end

    always_ff @(posedge i_clk) begin
        r_cnt_q <= cnt_mem[cnt_addr];
        if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= KLEN_RST;
            r_paired   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KMER_LEN: r_kmer_len <= i_cfg_data;
                CFG_PAIRED:   r_paired   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_sweep_tbl <= 1'b1;
            r_window    <= '0;
            r_clean     <= '0;
            r_hit       <= 1'b0;
            r_open      <= 1'b0;
            r_used      <= '0;
            r_decoy     <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            // The result register fills from the emit state and empties when drained.
            r_ov    <= ((r_state == S_EMIT) && res_free) || (r_ov && !o_res.ready);
            unique case (r_state)
                S_SWEEP: r_sweep <= r_sweep + 1'b1;
                S_IDLE: begin
                    if (req_acc && i_req.command == CMD_BASE) begin
                        // Without a probe the end of the read is handled at once.
                        if (!do_probe && i_req.end_of_read) begin
                            r_hit    <= hit_start && r_paired && !i_req.second_mate;
                            r_window <= '0;
                            r_clean  <= '0;
                            r_open   <= 1'b0;
                        end else begin
                            r_window <= win_next;
                            r_clean  <= clean_next;
                            r_hit    <= hit_start;
                            r_open   <= 1'b1;
                        end
                    end
                    if (req_acc && i_req.command == CMD_CLEAR) begin
                        r_decoy     <= '0;
                        r_sweep     <= '0;
                        r_sweep_tbl <= 1'b0;
                    end
                end
                S_CHECK: begin
                    if (r_is_base && ent_match) begin
                        r_hit <= 1'b1;
                        if (r_tbl_q.decoy && !(&r_decoy)) r_decoy <= r_decoy + 1'b1;
                    end
                    if (!r_is_base && ent_free && r_used < USED_N) r_used <= r_used + 1'b1;
                end
                S_FINBASE: begin
                    if (r_eor) begin
                        r_hit    <= r_hit && r_paired && !r_mate2;
                        r_window <= '0;
                        r_clean  <= '0;
                        r_open   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Request context, hash pipeline and result payload.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pcnt      <= '0;
                r_is_base   <= (i_req.command == CMD_BASE);
                r_is_query  <= (i_req.command == CMD_QUERY);
                r_tag_decoy <= (i_req.command == CMD_DECOY);
                r_tag_alt   <= (i_req.command == CMD_LOAD) && i_req.alt_allele;
                r_site      <= (i_req.command == CMD_DECOY) ? 14'd0 : i_req.site_index;
                r_eor       <= i_req.end_of_read;
                r_mate2     <= i_req.second_mate;
                r_key       <= (i_req.command == CMD_BASE)
                               ? (win_next & key_mask(k_eff))
                               : (i_req.pattern_key & key_mask(k_eff));
                // Only a pattern load and a query look at the site range.
                r_status    <= ({3'd0, i_req.site_index} >= SITE_N
                                && (i_req.command == CMD_LOAD || i_req.command == CMD_QUERY))
                               ? ST_RANGE : ST_OK;
            end
            S_MUL: begin
                r_pll <= 64'(r_key[31:0]) * 64'(HASH_MUL[31:0]);
                r_plh <= 32'(r_key[31:0] * HASH_MUL[63:32]);
                r_phl <= 32'(r_key[63:32] * HASH_MUL[31:0]);
            end
            S_SUM: begin
                r_hash  <= h_sum ^ (h_sum >> 29);
                r_rem   <= '0;
                r_mstep <= '0;
            end
            S_MOD: begin
                if (TBL_POW2) begin
                    r_slot <= r_hash[TW-1:0];
                end else begin
                    r_rem   <= rem_steps;
                    r_slot  <= rem_steps[TW-1:0];
                    r_hash  <= {r_hash[55:0], 8'd0};
                    r_mstep <= r_mstep + 3'd1;
                end
            end
            S_CHECK: begin
                r_pcnt    <= r_pcnt + 1'b1;
                r_slot    <= (r_slot == TBL_TOP) ? '0 : r_slot + 1'b1;
                r_cnt_alt <= r_tbl_q.alt;
                if (r_is_base && ent_match) r_site <= r_tbl_q.site;
                if (!r_is_base) begin
                    if (ent_free && r_used >= USED_N) r_status <= ST_FULL;
                    else if (!ent_free && !ent_match && probe_last) r_status <= ST_FULL;
                end
            end
            S_EMIT: begin
                if (res_free) begin
                    r_o_status <= r_status;
                    if (r_is_query && r_status == ST_OK) begin
                        r_o_ref   <= 32'(cnt_ref_q);
                        r_o_alt   <= 32'(cnt_alt_q);
                        r_o_decoy <= 32'(r_decoy);
                    end else begin
                        r_o_ref   <= '0;
                        r_o_alt   <= '0;
                        r_o_decoy <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_res.valid       = r_ov;
    assign o_res.status      = r_o_status;
    assign o_res.ref_count   = r_o_ref;
    assign o_res.alt_count   = r_o_alt;
    assign o_res.decoy_count = r_o_decoy;

    `KMAC_ASSERT(a_used_step, !$stable(r_used) |-> (r_used == $past(r_used) + 1'b1), "fill step")
    `KMAC_ASSERT(a_cnt_we_src, cnt_we |-> (r_state == S_SWEEP || r_state == S_CWRITE), "cnt write")
    `KMAC_ASSERT(a_sweep_block, (r_state == S_SWEEP) |-> !i_req.ready, "request during sweep")

endmodule
`default_nettype wire

// File: bench/tb_kmer_match_allele_counter_core.sv
// Testbench of the k-mer allele counter: random and directed requests against a predictor.
`default_nettype none
module tb_kmer_match_allele_counter_core;
    import kmac_pkg::*;

    // Commands 5 to 7 are not defined; the block must take them and stay silent.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int unsigned N_SLOTS = TABLE_ENTRIES_DEF;
    localparam int unsigned N_SITES = SITE_COUNT_DEF;
    // Cycles allowed for a read base that still probes the table after the last result.
    localparam int unsigned SETTLE_CYCLES = 300;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [13:0] site;
        logic        alt;
        logic [7:0]  ch;
        logic        eor;
        logic        mate2;
    } t_req;

    typedef struct {
        t_status     status;
        logic [31:0] ref_cnt;
        logic [31:0] alt_cnt;
        logic [31:0] decoy_cnt;
    } t_counts;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [5:0] i_cfg_data;

    kmac_in_if  req_if ();
    kmac_out_if res_if ();

    kmer_match_allele_counter_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Requests waiting to be offered, and the results the predictor expects.
    t_req    pending_reqs[$];
    t_counts expected_counts[$];

    // Predictor state: the pattern table image, the counters and the read scan.
    t_tbl_ent    table_img[int];
    int unsigned slots_used;
    logic [31:0] ref_tally[N_SITES];
    logic [31:0] alt_tally[N_SITES];
    logic [31:0] decoy_tally;
    logic [63:0] window_bits;
    logic [5:0]  clean_run;
    logic        read_hit;
    logic        read_open;
    logic [5:0]  klen_reg;
    logic        paired_reg;

    int unsigned mismatches;
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_settings;
    bit          calm;
    bit          took;
    int unsigned hold_cycles;

    logic [7:0] acgt[4];

    function automatic logic [5:0] active_k();
        if (klen_reg == 6'd0) return KLEN_MIN;
        if (klen_reg > KLEN_MAX) return KLEN_MAX;
        return klen_reg;
    endfunction

    function automatic logic [63:0] kmer_bits(input logic [5:0] k);
        if (k >= KLEN_MAX) return '1;
        return (64'd1 << (2 * k)) - 64'd1;
    endfunction

    function automatic int hash_slot(input logic [63:0] key);
        logic [63:0] h;
        h = key * HASH_MUL;
        h = h ^ (h >> 29);
        return int'(h % N_SLOTS);
    endfunction

    // Linear probe: the slot holding the key, else the first free slot, else -1.
    function automatic int find_slot(input logic [63:0] key);
        int s;
        s = hash_slot(key);
        for (int n = 0; n < N_SLOTS; n++) begin
            if (!table_img.exists(s)) return s;
            if (table_img[s].key == key) return s;
            s = (s + 1) % N_SLOTS;
        end
        return -1;
    endfunction

    function automatic t_status store_pattern(input logic [63:0] key, input logic decoy,
                                              input logic alt, input logic [13:0] site);
        int s;
        t_tbl_ent e;
        s = find_slot(key);
        if (s < 0) return ST_FULL;
        if (!table_img.exists(s)) begin
            if (slots_used >= N_SLOTS) return ST_FULL;
            slots_used++;
        end
        e.valid = 1'b1;
        e.decoy = decoy;
        e.alt   = alt;
        e.site  = site;
        e.key   = key;
        table_img[s] = e;
        return ST_OK;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] c);
        return (c == '1) ? c : c + 32'd1;
    endfunction

    task automatic scan_base(input t_req r);
        logic [2:0] code;
        logic [5:0] k;
        int s;
        k = active_k();
        code = 3'd4;
        if (!read_open) begin
            if (!r.mate2) read_hit = 1'b0;
            read_open = 1'b1;
        end
        for (int i = 0; i < 4; i++) if (r.ch == acgt[i]) code = 3'(i);
        if (code < 3'd4) begin
            window_bits = {window_bits[61:0], code[1:0]};
            if (clean_run < KLEN_MAX) clean_run++;
        end else begin
            clean_run = 6'd0;
        end
        if (code < 3'd4 && clean_run >= k && !read_hit) begin
            s = find_slot(window_bits & kmer_bits(k));
            if (s >= 0 && table_img.exists(s)) begin
                if (table_img[s].decoy) decoy_tally = bump(decoy_tally);
                else if (table_img[s].alt)
                    alt_tally[table_img[s].site] = bump(alt_tally[table_img[s].site]);
                else ref_tally[table_img[s].site] = bump(ref_tally[table_img[s].site]);
                read_hit = 1'b1;
            end
        end
        if (r.eor) begin
            read_hit    = read_hit && paired_reg && !r.mate2;
            window_bits = '0;
            clean_run   = 6'd0;
            read_open   = 1'b0;
        end
    endtask

    // Works out what one accepted request does and what result, if any, it owes.
    task automatic predict_request(input t_req r);
        t_counts res;
        res = '{ST_OK, 32'd0, 32'd0, 32'd0};
        if (r.cmd >= CMD_SPARE_FIRST) return;
        case (t_cmd'(r.cmd))
            CMD_BASE: begin
                scan_base(r);
                return;
            end
            CMD_LOAD: begin
                if (r.site >= N_SITES) res.status = ST_RANGE;
                else res.status = store_pattern(r.key & kmer_bits(active_k()), 1'b0,
                                                 r.alt, r.site);
            end
            CMD_DECOY: begin
                res.status = store_pattern(r.key & kmer_bits(active_k()), 1'b1, 1'b0, '0);
            end
            CMD_QUERY: begin
                if (r.site >= N_SITES) begin
                    res.status = ST_RANGE;
                end else begin
                    res.ref_cnt   = ref_tally[r.site];
                    res.alt_cnt   = alt_tally[r.site];
                    res.decoy_cnt = decoy_tally;
                end
            end
            default: begin
                foreach (ref_tally[i]) begin
                    ref_tally[i] = '0;
                    alt_tally[i] = '0;
                end
                decoy_tally = '0;
            end
        endcase
        expected_counts.push_back(res);
    endtask

    // Request with every field random, so that the unused fields toggle too.
    function automatic t_req noise_req(input logic [2:0] cmd);
        t_req r;
        r.cmd   = cmd;
        r.key   = {$urandom, $urandom};
        r.site  = 14'($urandom);
        r.alt   = 1'($urandom);
        r.ch    = 8'($urandom);
        r.eor   = 1'($urandom);
        r.mate2 = 1'($urandom);
        return r;
    endfunction

    task automatic queue_load(input logic [63:0] key, input logic [13:0] site,
                              input logic alt);
        t_req r;
        r = noise_req(CMD_LOAD);
        r.key  = key;
        r.site = site;
        r.alt  = alt;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_simple(input logic [2:0] cmd, input logic [13:0] site);
        t_req r;
        r = noise_req(cmd);
        r.site = site;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == ASCII_A || c == ASCII_C || c == ASCII_G || c == ASCII_T);
        return c;
    endfunction

    // Form 0 embeds the pattern in clean flanks, form 1 spoils one base of it,
    // form 2 is shorter than k (one base when k is one), and form 3 is random characters.
    task automatic queue_read(input int kk, input logic [63:0] key, input int form,
                              input logic mate2);
        logic [7:0] chars[$];
        int pre;
        int len;
        t_req r;
        pre = $urandom_range(0, 5);
        if (form == 2) begin
            len = (kk > 1) ? $urandom_range(1, kk - 1) : 1;
            repeat (len) chars.push_back(acgt[$urandom_range(0, 3)]);
        end else if (form == 3) begin
            len = $urandom_range(1, 40);
            repeat (len) chars.push_back($urandom_range(0, 1) ? acgt[$urandom_range(0, 3)]
                                                               : junk_char());
        end else begin
            repeat (pre) chars.push_back(acgt[$urandom_range(0, 3)]);
            for (int i = kk - 1; i >= 0; i--) chars.push_back(acgt[key[2 * i +: 2]]);
            repeat ($urandom_range(0, 5)) chars.push_back(acgt[$urandom_range(0, 3)]);
            if (form == 1) chars[pre + $urandom_range(0, kk - 1)] = junk_char();
        end
        foreach (chars[i]) begin
            r = noise_req(CMD_BASE);
            r.ch    = chars[i];
            r.eor   = (i == chars.size() - 1);
            r.mate2 = mate2;
            pending_reqs.push_back(r);
        end
    endtask

    // Register writes land on a rising edge; the predictor copy follows at once
    // because writes only happen while the block is idle.
    task automatic write_reg(input logic [0:0] idx, input logic [5:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KMER_LEN) klen_reg = data;
        else paired_reg = data[0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_counts.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Request driver: holds an offered request until it is taken, otherwise
    // offers the next one unless this cycle is an idle one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && !took)) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
                req_if.valid       <= 1'b1;
                req_if.command     <= pending_reqs[0].cmd;
                req_if.pattern_key <= pending_reqs[0].key;
                req_if.site_index  <= pending_reqs[0].site;
                req_if.alt_allele  <= pending_reqs[0].alt;
                req_if.base_char   <= pending_reqs[0].ch;
                req_if.end_of_read <= pending_reqs[0].eor;
                req_if.second_mate <= pending_reqs[0].mate2;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        took = 1'b0;
    end

    // Result receiver: a long hold-off when asked for, else random stalls unless calm.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            res_if.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            res_if.ready <= calm || ($urandom_range(0, 99) >= 17);
        end
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge i_clk) begin
        t_req r;
        t_counts e;
        if (i_rst_n && req_if.valid && req_if.ready && pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            took = 1'b1;
            n_requests++;
            predict_request(r);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            if (expected_counts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, status %0d", res_if.status);
            end else begin
                e = expected_counts.pop_front();
                if (res_if.status !== e.status || res_if.ref_count !== e.ref_cnt ||
                    res_if.alt_count !== e.alt_cnt || res_if.decoy_count !== e.decoy_cnt) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected st %0d ref %0d alt %0d decoy %0d",
                                 e.status, e.ref_cnt, e.alt_cnt, e.decoy_cnt);
                        $display("                 got st %0d ref %0d alt %0d decoy %0d",
                                 res_if.status, res_if.ref_count, res_if.alt_count,
                                 res_if.decoy_count);
                    end
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int klens[8];
        logic [63:0] loaded[$];
        logic [63:0] key;
        int kk;
        int form;
        int phase;
        acgt = '{ASCII_A, ASCII_C, ASCII_G, ASCII_T};
        klens = '{21, 1, 32, 0, 63, 5, 12, 8};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.command = '0;
        req_if.pattern_key = '0;
        req_if.site_index = '0;
        req_if.alt_allele = 1'b0;
        req_if.base_char = '0;
        req_if.end_of_read = 1'b0;
        req_if.second_mate = 1'b0;
        res_if.ready = 1'b0;
        hold_cycles = 0;
        calm = 1'b0;
        took = 1'b0;
        mismatches = 0;
        n_requests = 0;
        n_results = 0;
        n_settings = 0;
        slots_used = 0;
        foreach (ref_tally[i]) begin
            ref_tally[i] = '0;
            alt_tally[i] = '0;
        end
        decoy_tally = '0;
        window_bits = '0;
        clean_run = '0;
        read_hit = 1'b0;
        read_open = 1'b0;
        klen_reg = KLEN_RST;
        paired_reg = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening at the reset length of 21: extreme keys and sites,
        // a duplicate key, a decoy, undefined commands, a spoiled and a short
        // read, a query before and after a clear.
        queue_simple(CMD_QUERY, 14'd0);
        queue_load('1, 14'h3FFF, 1'b1);
        queue_load('0, 14'd0, 1'b0);
        queue_load('0, 14'd1, 1'b1);
        queue_load(64'h0000_0123_4567_89AB, 14'd2, 1'b0);
        pending_reqs.push_back(noise_req(CMD_DECOY));
        pending_reqs[$].key = 64'h0000_0FED_CBA9_8765;
        for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
            pending_reqs.push_back(noise_req(3'(c)));
        queue_read(21, '1, 0, 1'b0);
        queue_read(21, '0, 1, 1'b0);
        queue_read(21, '0, 2, 1'b0);
        queue_read(21, '0, 0, 1'b0);
        queue_read(21, 64'h0000_0FED_CBA9_8765, 0, 1'b0);
        queue_simple(CMD_QUERY, 14'h3FFF);
        queue_simple(CMD_QUERY, 14'd1);
        queue_simple(CMD_CLEAR, 14'd0);
        queue_simple(CMD_QUERY, 14'd1);
        wait_drained();

        // Random phases, one register setting each; every phase loads fresh
        // patterns at its own length and scans reads built around them.
        phase = 0;
        while (n_requests < 750 || phase < 8) begin
            write_reg(CFG_KMER_LEN, 6'(klens[phase % 8]));
            write_reg(CFG_PAIRED, 1'(phase % 2));
            n_settings++;
            kk = active_k();
            calm = (phase == 3);
            loaded.delete();
            repeat (10) begin
                key = {$urandom, $urandom};
                loaded.push_back(key & kmer_bits(6'(kk)));
                queue_load(key, 14'($urandom_range(0, 7)), 1'($urandom));
            end
            pending_reqs.push_back(noise_req(CMD_DECOY));
            loaded.push_back(pending_reqs[$].key & kmer_bits(6'(kk)));
            queue_load(loaded[0], 14'($urandom_range(0, 7)), 1'($urandom));
            if (phase == 2) hold_cycles = 400;
            repeat (paired_reg ? 2 : 3) begin
                form = $urandom_range(0, 99);
                form = form < 60 ? 0 : form < 75 ? 1 : form < 85 ? 2 : 3;
                key = loaded[$urandom_range(0, loaded.size() - 1)];
                if (paired_reg) begin
                    queue_read(kk, key, form, 1'b0);
                    queue_read(kk, loaded[$urandom_range(0, loaded.size() - 1)], 0, 1'b1);
                end else begin
                    queue_read(kk, key, form, 1'($urandom));
                end
            end
            for (int s = 0; s < 8; s++) queue_simple(CMD_QUERY, 14'(s));
            if (phase % 3 == 2) queue_simple(CMD_CLEAR, 14'($urandom));
            wait_drained();
            phase++;
        end

        $display("Ran %0d requests and checked %0d results over %0d register settings,",
                 n_requests, n_results, n_settings);
        $display("with %0d table entries in use at the end.", slots_used);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
